[sv/m4mul_pkg.sv]
// ----------------------------------------------------------------------------
// m4mul_pkg
// Types and constants shared by the fixed-point matrix multiplier modules.
// ----------------------------------------------------------------------------
package m4mul_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned DATA_W = 32;

  // Largest store address width over the supported matrix sizes (up to 8x8)
  localparam int unsigned MAX_ADDR_W = 6;

  // Right shift that turns a Q32.32 product sum back into Q16.16
  localparam int unsigned FRAC_W = 16;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic                     operand_side;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     compute_after;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
    logic                     last_element;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic                  first;
    logic                  last;
    logic                  last_elem;
    logic [IDX_W-1:0]      elem_idx;
    logic [MAX_ADDR_W-1:0] left_addr;
    logic [MAX_ADDR_W-1:0] right_addr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_taken;
  } sts_t;

endpackage

[sv/matrix4_multiply.sv]
// ----------------------------------------------------------------------------
// matrix4_multiply
// Fixed-point (Q16.16) DIM x DIM matrix multiplier with element load port.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   in_      | in_valid / in_stall | side, index, element, compute flag
//   out_     | out_valid/out_stall | index, product element, saturated, last
//
// Load items are taken back to back while no compute is running.
// A compute item stores its element, then emits DIM*DIM results one at a
// time through the one shared multiply-accumulate unit (read, multiply,
// accumulate, output register); the next result is issued once the previous
// one transfers. in_stall stays high until the last result transfers.
// out_stall holds the output register and the sequencer.
// Reset is synchronous; the element stores are not cleared.
// ----------------------------------------------------------------------------
module matrix4_multiply #(
  parameter int DIM = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  m4mul_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output m4mul_pkg::out_item_t out_data
);

  m4mul_pkg::cmd_t cmd;
  m4mul_pkg::sts_t sts;

  m4mul_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_compute_after (in_data.compute_after),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .sts              (sts)
  );

  m4mul_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sv/m4mul_ctrl.sv]
// ----------------------------------------------------------------------------
// m4mul_ctrl
// Sequencer: takes load items, then walks row, column and inner index to
// issue store reads for each product element, one element at a time.
// ----------------------------------------------------------------------------
module m4mul_ctrl #(
  parameter int DIM = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_compute_after,
  output logic             in_stall,
  output m4mul_pkg::cmd_t  cmd,
  input  m4mul_pkg::sts_t  sts
);

  localparam int CW = $clog2(DIM);

  m4mul_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] r_r, r_nxt;

  logic       accept;
  logic       last_k, last_c, last_r;
  logic [7:0] left_addr8, right_addr8, elem8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m4mul_pkg::ST_IDLE;
      k_r     <= '0;
      c_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      c_r     <= c_nxt;
      r_r     <= r_nxt;
    end
  end

  assign last_k = (k_r == CW'(DIM - 1));
  assign last_c = (c_r == CW'(DIM - 1));
  assign last_r = (r_r == CW'(DIM - 1));

  assign left_addr8  = 8'(r_r) * 8'(DIM) + 8'(k_r);
  assign right_addr8 = 8'(k_r) * 8'(DIM) + 8'(c_r);
  assign elem8       = 8'(r_r) * 8'(DIM) + 8'(c_r);

  assign in_stall = (state_r != m4mul_pkg::ST_IDLE);
  assign accept   = in_valid && (state_r == m4mul_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    r_nxt          = r_r;
    cmd            = '0;
    cmd.wr_en      = accept;
    cmd.first      = (k_r == '0);
    cmd.last       = last_k;
    cmd.last_elem  = last_c && last_r;
    cmd.elem_idx   = elem8[m4mul_pkg::IDX_W-1:0];
    cmd.left_addr  = left_addr8[m4mul_pkg::MAX_ADDR_W-1:0];
    cmd.right_addr = right_addr8[m4mul_pkg::MAX_ADDR_W-1:0];
    unique case (state_r)
      m4mul_pkg::ST_IDLE: begin
        if (accept && in_compute_after) begin
          state_nxt = m4mul_pkg::ST_ISSUE;
          k_nxt     = '0;
          c_nxt     = '0;
          r_nxt     = '0;
        end
      end
      m4mul_pkg::ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = m4mul_pkg::ST_WAIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      m4mul_pkg::ST_WAIT: begin
        // hold until the finished element is transferred out
        if (sts.out_taken) begin
          if (last_c && last_r) begin
            state_nxt = m4mul_pkg::ST_IDLE;
          end else begin
            state_nxt = m4mul_pkg::ST_ISSUE;
            if (last_c) begin
              c_nxt = '0;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = m4mul_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/m4mul_dp.sv]
// ----------------------------------------------------------------------------
// m4mul_dp
// Datapath: left and right element stores, read stage, 32x32 multiplier,
// wide accumulator, shift/saturate and the output register.
// ----------------------------------------------------------------------------
module m4mul_dp #(
  parameter int DIM = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  m4mul_pkg::in_item_t  in_data,
  input  m4mul_pkg::cmd_t      cmd,
  output m4mul_pkg::sts_t      sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output m4mul_pkg::out_item_t out_data
);

  localparam int NUM   = DIM * DIM;
  localparam int AW    = $clog2(NUM);
  localparam int ACC_W = 64 + $clog2(DIM);
  localparam int TOP_W = ACC_W - 47;

  typedef struct packed {
    logic                        first;
    logic                        last;
    logic                        last_elem;
    logic [m4mul_pkg::IDX_W-1:0] elem_idx;
  } tag_t;

  logic [m4mul_pkg::DATA_W-1:0] left_mem  [NUM];
  logic [m4mul_pkg::DATA_W-1:0] right_mem [NUM];

  logic [7:0] wr_idx8;
  logic       wr_ok;

  logic                        rd_vld_r, mul_vld_r, acc_vld_r;
  tag_t                        rd_tag_r, mul_tag_r;
  logic                        acc_last_elem_r;
  logic [m4mul_pkg::IDX_W-1:0] acc_idx_r;
  logic signed [31:0]          lrd_r, rrd_r;
  logic signed [63:0]          prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [ACC_W-1:0]     prod_ext;

  logic [TOP_W-1:0]             acc_top;
  logic                         fits;
  logic [m4mul_pkg::DATA_W-1:0] fin_value;

  logic                 out_valid_r;
  m4mul_pkg::out_item_t out_data_r;
  logic                 out_taken;

  // Store writes; an index past the last entry stores nothing
  assign wr_idx8 = 8'(in_data.element_index);
  assign wr_ok   = cmd.wr_en && (wr_idx8 < 8'(NUM));

  always_ff @(posedge clk) begin
    if (wr_ok && (in_data.operand_side == m4mul_pkg::SIDE_LEFT)) begin
      left_mem[wr_idx8[AW-1:0]] <= in_data.element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok && (in_data.operand_side == m4mul_pkg::SIDE_RIGHT)) begin
      right_mem[wr_idx8[AW-1:0]] <= in_data.element_value;
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lrd_r <= left_mem[cmd.left_addr[AW-1:0]];
      rrd_r <= right_mem[cmd.right_addr[AW-1:0]];
    end
    rd_tag_r.first     <= cmd.first;
    rd_tag_r.last      <= cmd.last;
    rd_tag_r.last_elem <= cmd.last_elem;
    rd_tag_r.elem_idx  <= cmd.elem_idx;
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r    <= lrd_r * rrd_r;
    mul_tag_r <= rd_tag_r;
  end

  assign prod_ext = {{(ACC_W-64){prod_r[63]}}, prod_r};

  // Accumulate stage: the first product of an element restarts the sum
  always_ff @(posedge clk) begin
    if (mul_vld_r) begin
      acc_r <= mul_tag_r.first ? prod_ext : acc_r + prod_ext;
    end
    acc_last_elem_r <= mul_tag_r.last_elem;
    acc_idx_r       <= mul_tag_r.elem_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      acc_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.rd_en;
      mul_vld_r <= rd_vld_r;
      acc_vld_r <= mul_vld_r && mul_tag_r.last;
    end
  end

  // Shift right by the fraction width; the sum fits when every bit from
  // bit 47 up matches the sign
  assign acc_top   = acc_r[ACC_W-1:47];
  assign fits      = (&acc_top) || (~|acc_top);
  assign fin_value = fits ? acc_r[m4mul_pkg::FRAC_W +: m4mul_pkg::DATA_W]
                   : (acc_r[ACC_W-1] ? m4mul_pkg::SAT_NEG : m4mul_pkg::SAT_POS);

  assign out_taken = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_vld_r) begin
      out_valid_r <= 1'b1;
    end else if (out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_vld_r) begin
      out_data_r.result_index <= acc_idx_r;
      out_data_r.result_value <= fin_value;
      out_data_r.saturated    <= !fits;
      out_data_r.last_element <= acc_last_elem_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.out_taken = out_taken;

endmodule

[sv/m4mul_checker.sv]
// ----------------------------------------------------------------------------
// m4mul_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module m4mul_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input m4mul_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input m4mul_pkg::out_item_t out_data
);

  // No new input while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A compute transfer locks the input side
  a_compute_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.compute_after) |=> in_stall)
    else $error("input not held after compute request");

  // Clamped results take one of the two limit values
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.result_value == m4mul_pkg::SAT_POS ||
       out_data.result_value == m4mul_pkg::SAT_NEG))
    else $error("saturated result not at a limit");

  // Nothing follows the final element right away
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_element) |=> !out_valid)
    else $error("result after the final element");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind matrix4_multiply m4mul_checker u_m4mul_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/matrix4_multiply_test.sv]
// ----------------------------------------------------------------------------
// matrix4_multiply_test
// Loads left and right Q16.16 matrix elements, requests products and checks
// every emitted element against a local fixed-point multiply with clamping.
// Covers exact and just-over range limits, flooring of negative sums, both
// store sides, long receiver hold-off, back-to-back bursts and a random stream.
// ----------------------------------------------------------------------------
module matrix4_multiply_test;

  localparam int DIM             = 4;
  localparam int NUM_ELEMS       = DIM * DIM;
  localparam int ACC_W           = 128;
  localparam int RANDOM_ITEMS    = 280;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 24;
  localparam int LIMIT_CYCLES    = 2000000;

  localparam logic signed [m4mul_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  m4mul_pkg::in_item_t  in_data  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  m4mul_pkg::out_item_t out_data;

  matrix4_multiply #(
    .DIM(DIM)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  logic signed [m4mul_pkg::DATA_W-1:0] left_store  [NUM_ELEMS];
  logic signed [m4mul_pkg::DATA_W-1:0] right_store [NUM_ELEMS];
  m4mul_pkg::out_item_t                expected_products [$];

  int     mismatches         = 0;
  int     elements_sent      = 0;
  int     products_requested = 0;
  int     results_checked    = 0;
  int     clamped_seen       = 0;
  longint cycle_count        = 0;
  bit     in_idle_on         = 1'b1;
  bit     out_idle_on        = 1'b1;
  bit     hold_off_req       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d products still expected", $time,
               cycle_count, expected_products.size());
      $display("FAIL matrix4_multiply");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  // Roughly -8.0 to +8.0, so that row sums stay in range
  function automatic logic signed [m4mul_pkg::DATA_W-1:0] pick_small_value();
    logic [m4mul_pkg::DATA_W-1:0] raw;
    raw = $urandom_range(0, 32'h0010_0000);
    return $signed(raw) - 32'sh0008_0000;
  endfunction

  function automatic logic signed [m4mul_pkg::DATA_W-1:0] pick_element_value();
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: return m4mul_pkg::SAT_POS;
        1: return m4mul_pkg::SAT_NEG;
        2: return '0;
        3: return '1;
        4: return Q_ONE;
        default: return -Q_ONE;
      endcase
    end
    if (roll < 3) return $urandom();
    return pick_small_value();
  endfunction

  function automatic void store_element(input m4mul_pkg::in_item_t item);
    if (item.element_index < NUM_ELEMS) begin
      if (item.operand_side == m4mul_pkg::SIDE_RIGHT)
        right_store[item.element_index] = item.element_value;
      else
        left_store[item.element_index] = item.element_value;
    end
  endfunction

  // Full-precision products, wide sum, floor shift, clamp to 32 bits
  function automatic void predict_product();
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [63:0]      prod;
    m4mul_pkg::out_item_t    want;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          prod = left_store[r*DIM+k] * right_store[k*DIM+c];
          acc  = acc + prod;
        end
        shifted = acc >>> m4mul_pkg::FRAC_W;
        want.result_index = m4mul_pkg::IDX_W'(r*DIM + c);
        if (shifted[ACC_W-1:m4mul_pkg::DATA_W-1] ==
            {(ACC_W-m4mul_pkg::DATA_W+1){shifted[ACC_W-1]}}) begin
          want.result_value = shifted[m4mul_pkg::DATA_W-1:0];
          want.saturated    = 1'b0;
        end else begin
          want.result_value = shifted[ACC_W-1] ? m4mul_pkg::SAT_NEG : m4mul_pkg::SAT_POS;
          want.saturated    = 1'b1;
        end
        want.last_element = (r*DIM + c == NUM_ELEMS - 1);
        expected_products.push_back(want);
      end
    end
  endfunction

  task automatic transfer_element(input logic side, input int idx,
                                  input logic signed [m4mul_pkg::DATA_W-1:0] value,
                                  input logic go);
    m4mul_pkg::in_item_t item;
    int                  gap;
    item.operand_side  = side;
    item.element_index = m4mul_pkg::IDX_W'(idx);
    item.element_value = value;
    item.compute_after = go;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    store_element(item);
    elements_sent++;
    if (go) begin
      products_requested++;
      predict_product();
    end
  endtask

  task automatic send_random_element(input logic go);
    transfer_element($urandom_range(0, 1), $urandom_range(0, NUM_ELEMS - 1),
                     pick_element_value(), go);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver_stall
    int stretch;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
        stretch = pick_gap() + 1;
        out_stall <= 1'b1;
        repeat (stretch) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : product_checker
    m4mul_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product transfer, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = expected_products.pop_front();
        results_checked++;
        if (want.saturated) clamped_seen++;
        if (out_data.result_index !== want.result_index) begin
          $display("%0t: result_index expected %0d, actual %0d", $time,
                   want.result_index, out_data.result_index);
          mismatches++;
        end
        if (out_data.result_value !== want.result_value) begin
          $display("%0t: result_value at %0d expected %h, actual %h", $time,
                   want.result_index, want.result_value, out_data.result_value);
          mismatches++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated at %0d expected %b, actual %b", $time,
                   want.result_index, want.saturated, out_data.saturated);
          mismatches++;
        end
        if (out_data.last_element !== want.last_element) begin
          $display("%0t: last_element at %0d expected %b, actual %b", $time,
                   want.result_index, want.last_element, out_data.last_element);
          mismatches++;
        end
      end
    end
  end

  // Fill both stores: identity on the left, range limits and -1 LSB on the right
  task automatic test_identity_load();
    logic signed [m4mul_pkg::DATA_W-1:0] value;
    for (int i = 0; i < NUM_ELEMS; i++)
      transfer_element(m4mul_pkg::SIDE_LEFT, i, (i % (DIM + 1) == 0) ? Q_ONE : '0, 1'b0);
    for (int i = 0; i < NUM_ELEMS; i++) begin
      case (i)
        1:       value = m4mul_pkg::SAT_POS;
        2:       value = m4mul_pkg::SAT_NEG;
        10:      value = m4mul_pkg::SAT_POS;
        15:      value = '1;
        default: value = pick_small_value();
      endcase
      transfer_element(m4mul_pkg::SIDE_RIGHT, i, value, i == NUM_ELEMS - 1);
    end
    wait_drained();
  endtask

  // Clamp both ways, just over the positive limit, and floor of -0.5
  task automatic test_saturation_edges();
    transfer_element(m4mul_pkg::SIDE_LEFT, 0, m4mul_pkg::SAT_POS, 1'b0);
    transfer_element(m4mul_pkg::SIDE_RIGHT, 0, m4mul_pkg::SAT_POS, 1'b0);
    transfer_element(m4mul_pkg::SIDE_LEFT, 5, m4mul_pkg::SAT_NEG, 1'b0);
    transfer_element(m4mul_pkg::SIDE_RIGHT, 5, m4mul_pkg::SAT_POS, 1'b1);
    transfer_element(m4mul_pkg::SIDE_LEFT, 10, 32'sh0001_0001, 1'b0);
    transfer_element(m4mul_pkg::SIDE_LEFT, 15, 32'sh0000_8000, 1'b1);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < 10; i++) send_random_element(i == 4 || i == 9);
    wait_drained();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Hold the output long enough that the block backs up onto its input
  task automatic test_receiver_hold_off();
    out_idle_on = 1'b0;
    wait_drained();
    hold_off_req = 1'b1;
    while (out_stall !== 1'b1) @(posedge clk);
    send_random_element(1'b1);
    for (int i = 0; i < 4; i++) send_random_element(1'b0);
    wait_drained();
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    bit quiet;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet       = ((i / 50) % 3) == 1;
      in_idle_on  = !quiet;
      out_idle_on = !quiet;
      send_random_element($urandom_range(0, 7) == 0);
    end
    wait_drained();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_identity_load();
    test_saturation_edges();
    test_back_to_back();
    test_receiver_hold_off();
    test_random_stream();
    $display("Loaded %0d elements and requested %0d products, range limits and floor shift",
             elements_sent, products_requested);
    $display("included; %0d product elements compared, %0d clamped, %0d mismatches.",
             results_checked, clamped_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS matrix4_multiply");
    end else begin
      $display("FAIL matrix4_multiply");
    end
    $finish;
  end

endmodule
